>>> rtl/cmp_pkg.sv
// shared constants and types for the coin majority probability core
`timescale 1ns / 1ps
package cmp_pkg;

  localparam int MAX_COINS = 1024;
  localparam int DEPTH     = MAX_COINS + 1;
  localparam int CNT_W     = $clog2(MAX_COINS + 1);
  localparam int DIST_W    = 25;
  localparam int PROB_W    = 17;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = DIST_W + PROB_W;
  localparam int ACC_W     = DIST_W + $clog2(MAX_COINS);

  localparam logic [DIST_W-1:0] ONE_Q24   = DIST_W'(1 << 24);
  localparam logic [PROB_W-1:0] ONE_Q16   = PROB_W'(1 << FRAC_W);
  localparam logic [CNT_W-1:0]  MAX_COUNT = CNT_W'(MAX_COINS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_TAIL,
    ST_TAIL_DRAIN,
    ST_EMIT
  } state_t;

  // one entry update: new[addr] = upper*(1-p) + lower*p
  typedef struct packed {
    logic              valid;
    logic [CNT_W-1:0]  addr;
    logic [DIST_W-1:0] upper;
    logic [DIST_W-1:0] lower;
  } mac_req_t;

  typedef struct packed {
    logic              en;
    logic [CNT_W-1:0]  addr;
    logic [DIST_W-1:0] data;
  } mac_wr_t;

endpackage

>>> rtl/cmp_mac.sv
// registered multiply and combinational add that produces one updated distribution entry
`timescale 1ns / 1ps
module cmp_mac (
  input  logic                         clk,
  input  logic                         rst,
  input  cmp_pkg::mac_req_t            req,
  input  logic [cmp_pkg::PROB_W-1:0]   p,
  input  logic [cmp_pkg::PROB_W-1:0]   q,
  output cmp_pkg::mac_wr_t             wr
);
  import cmp_pkg::*;

  logic              valid;
  logic [CNT_W-1:0]  addr;
  logic [PROD_W-1:0] prod_u;
  logic [PROD_W-1:0] prod_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    addr   <= req.addr;
    prod_u <= PROD_W'(req.upper) * PROD_W'(q);
    prod_l <= PROD_W'(req.lower) * PROD_W'(p);
  end

  // each product truncated to q1.24 before the add
  assign wr.en   = valid;
  assign wr.addr = addr;
  assign wr.data = DIST_W'((prod_u >> FRAC_W) + (prod_l >> FRAC_W));

endmodule

>>> rtl/coin_majority_probability_core.sv
// top level: head-count distribution over coins, majority tail probability
//
//  group | dir | contents
//  s_*   | in  | tdata[16:0] coin_prob, tlast last_coin
//  m_*   | out | tdata[24:0] tail_prob, tdata[35:25] coin_total, tuser overflowed
//
// a coin taking the store from n to n+1 coins costs n+2 entry updates plus
// accept and pipeline drain; a last coin adds (n+2)/2 tail reads (rounded
// down) plus a tail drain; all paced by the single read port of the memory
// a coin beyond capacity is taken in idle with no sweep, plus the tail pass if it is last
// no clearing pass: entries above the coin count are never read
// input stalls only while a coin is being processed or a result cannot be loaded
`timescale 1ns / 1ps
module coin_majority_probability_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [16:0] coin_prob
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [24:0] tail_prob, [35:25] coin_total
  output logic        m_tuser    // [0] overflowed
);
  import cmp_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  coins_seen;
  logic              overflow_seen;
  logic [PROB_W-1:0] p_reg;
  logic [PROB_W-1:0] q_reg;
  logic              last_reg;
  logic              fresh;
  logic [CNT_W-1:0]  w;
  logic [CNT_W-1:0]  k;
  logic [ACC_W-1:0]  acc;
  logic              s1_v;
  logic              s1_zero;
  logic [CNT_W-1:0]  s1_addr;
  logic              t1_v;
  logic [DIST_W-1:0] upper;
  logic [DIST_W-1:0] lower_eff;
  logic [CNT_W-1:0]  rd_addr;
  logic [DIST_W-1:0] rdata;
  logic [DIST_W-1:0] mem [DEPTH];
  logic [PROB_W-1:0] p_in;
  logic              accept;
  logic              emit;
  logic              out_valid;
  logic [DIST_W-1:0] out_tail;
  logic [CNT_W-1:0]  out_total;
  logic              out_ovf;
  mac_req_t          req;
  mac_wr_t           wr;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign emit     = (state == ST_EMIT) && (!out_valid || m_tready);
  assign p_in     = (s_tdata[PROB_W-1:0] > ONE_Q16) ? ONE_Q16 : s_tdata[PROB_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = k;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (coins_seen < MAX_COUNT) begin
            state_next = ST_SWEEP;
          end else if (s_tlast) begin
            state_next = ST_TAIL;
          end
        end
      end
      ST_SWEEP: begin
        rd_addr = w - CNT_W'(1);
        if (w == '0) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_v && !wr.en) begin
          state_next = last_reg ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (k == coins_seen) begin
          state_next = ST_TAIL_DRAIN;
        end
      end
      ST_TAIL_DRAIN: begin
        if (!t1_v) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coins_seen    <= '0;
      overflow_seen <= 1'b0;
      s1_v          <= 1'b0;
      t1_v          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      s1_v <= (state == ST_SWEEP);
      t1_v <= (state == ST_TAIL);
      if (accept) begin
        if (coins_seen < MAX_COUNT) begin
          coins_seen <= coins_seen + CNT_W'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (emit) begin
        out_valid     <= 1'b1;
        coins_seen    <= '0;
        overflow_seen <= 1'b0;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // the store starts empty: entry zero reads as 1.0 while no coin is held
  assign lower_eff = s1_zero ? '0 : (fresh ? ONE_Q24 : rdata);

  always_ff @(posedge clk) begin
    if (accept) begin
      p_reg    <= p_in;
      q_reg    <= ONE_Q16 - p_in;
      last_reg <= s_tlast;
      fresh    <= (coins_seen == '0);
      w        <= coins_seen + CNT_W'(1);
      upper    <= '0;
      acc      <= '0;
    end else begin
      if (state == ST_SWEEP) begin
        w <= w - CNT_W'(1);
      end
      if (s1_v) begin
        upper <= lower_eff;
      end
      if (t1_v) begin
        acc <= acc + ACC_W'(rdata);
      end
    end
    s1_zero <= (w == '0);
    s1_addr <= w;
    if (state_next == ST_TAIL && state != ST_TAIL) begin
      k <= (coins_seen >> 1) + CNT_W'(1);
    end else if (state == ST_TAIL) begin
      k <= k + CNT_W'(1);
    end
  end

  assign req.valid = s1_v;
  assign req.addr  = s1_addr;
  assign req.upper = upper;
  assign req.lower = lower_eff;

  cmp_mac u_mac (
    .clk (clk),
    .rst (rst),
    .req (req),
    .p   (p_reg),
    .q   (q_reg),
    .wr  (wr)
  );

  // sweep reads run downward below the entry being written, so no overlap
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_tail  <= (acc > ACC_W'(ONE_Q24)) ? ONE_Q24 : acc[DIST_W-1:0];
      out_total <= coins_seen;
      out_ovf   <= overflow_seen;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0, out_total, out_tail};
  assign m_tuser  = out_ovf;

endmodule
